[hdl/rc4sc_pkg.sv]
package rc4sc_pkg;

    // Permutation and byte geometry
    localparam int unsigned PERM_SIZE   = 256;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PERM_AW     = $clog2(PERM_SIZE);

    // Key storage
    localparam int unsigned MAX_KEY_BYTES = 32;
    localparam int unsigned KEY_REGS      = 4;
    localparam int unsigned KEY_WORD_W    = 64;
    localparam int unsigned KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int unsigned KEY_LEN_W     = 6;

    // Text words
    localparam int unsigned CHAR_W = 16;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = KEY_WORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd4;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [KEY_WORD_W-1:0] t_key_word;

endpackage

[hdl/rc4_stream_cipher_unit.sv]
// A word on a running message goes from idle through PB, PC, PD and PE; PE registers
// the result and holds while the output register is full. A word that starts a message
// (or the first after reset) first runs key scheduling: FILL, then the KA..KD swap sweep
// over every entry, then PA. A new word is accepted only in idle, after the last has left PE.
// Reset (synchronous, active low) clears the i and j indices, key regs (length 1) and marks
// the key unscheduled; the permutation RAM is rebuilt at the next schedule.
module rc4_stream_cipher_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input words
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [rc4sc_pkg::CHAR_W-1:0]         i_text_char,
    input  logic                                 i_message_start,
    // output words
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [rc4sc_pkg::CHAR_W-1:0]         o_cipher_char
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_KA   = 4'd2;
    localparam logic [3:0] ST_KB   = 4'd3;
    localparam logic [3:0] ST_KC   = 4'd4;
    localparam logic [3:0] ST_KD   = 4'd5;
    localparam logic [3:0] ST_PA   = 4'd6;
    localparam logic [3:0] ST_PB   = 4'd7;
    localparam logic [3:0] ST_PC   = 4'd8;
    localparam logic [3:0] ST_PD   = 4'd9;
    localparam logic [3:0] ST_PE   = 4'd10;

    localparam rc4sc_pkg::t_byte LAST_ENTRY = rc4sc_pkg::t_byte'(rc4sc_pkg::PERM_SIZE - 1);

    logic [3:0]                            r_state;
    rc4sc_pkg::t_key_word                  r_key [rc4sc_pkg::KEY_REGS];
    logic [rc4sc_pkg::KEY_LEN_W-1:0]       r_key_len;
    logic [rc4sc_pkg::KEY_IDX_W-1:0]       r_k;
    rc4sc_pkg::t_byte                      r_n;
    rc4sc_pkg::t_byte                      r_i;
    rc4sc_pkg::t_byte                      r_j;
    rc4sc_pkg::t_byte                      r_si;
    rc4sc_pkg::t_byte                      r_sj;
    logic                                  r_byp;
    logic                                  r_sched;
    logic [rc4sc_pkg::CHAR_W-1:0]          r_text;
    logic [rc4sc_pkg::CHAR_W-1:0]          r_cipher;
    logic                                  r_ovalid;

    // permutation RAM, one write and one registered read per cycle
    rc4sc_pkg::t_byte                      r_perm [rc4sc_pkg::PERM_SIZE];
    rc4sc_pkg::t_byte                      r_rdata;

    logic                                  w_we;
    rc4sc_pkg::t_byte                      w_waddr;
    rc4sc_pkg::t_byte                      w_wdata;
    rc4sc_pkg::t_byte                      w_raddr;

    logic [rc4sc_pkg::MAX_KEY_BYTES*rc4sc_pkg::BYTE_W-1:0] w_key_flat;
    rc4sc_pkg::t_byte                      w_key_byte;
    logic [rc4sc_pkg::KEY_LEN_W-1:0]       w_len_eff;
    logic [rc4sc_pkg::KEY_LEN_W-1:0]       w_k_inc;
    logic [rc4sc_pkg::KEY_IDX_W-1:0]       w_k_next;
    rc4sc_pkg::t_byte                      w_i_inc;
    rc4sc_pkg::t_byte                      w_ks_j;
    rc4sc_pkg::t_byte                      w_pr_j;
    rc4sc_pkg::t_byte                      w_t;
    rc4sc_pkg::t_byte                      w_ks;
    logic                                  w_accept;

    // Key byte pick and cyclic key index
    assign w_key_flat = {r_key[3], r_key[2], r_key[1], r_key[0]};
    assign w_key_byte = w_key_flat[{r_k, 3'b000} +: rc4sc_pkg::BYTE_W];

    always_comb begin
        priority if (r_key_len == '0) begin
            w_len_eff = rc4sc_pkg::KEY_LEN_W'(1);
        end else if (r_key_len > rc4sc_pkg::KEY_LEN_W'(rc4sc_pkg::MAX_KEY_BYTES)) begin
            w_len_eff = rc4sc_pkg::KEY_LEN_W'(rc4sc_pkg::MAX_KEY_BYTES);
        end else begin
            w_len_eff = r_key_len;
        end
    end

    assign w_k_inc  = {1'b0, r_k} + rc4sc_pkg::KEY_LEN_W'(1);
    assign w_k_next = (w_k_inc >= w_len_eff) ? '0 : w_k_inc[rc4sc_pkg::KEY_IDX_W-1:0];

    // Index adders
    assign w_i_inc = r_i + 8'd1;
    assign w_ks_j  = r_j + r_rdata + w_key_byte;
    assign w_pr_j  = r_j + r_rdata;
    assign w_t     = r_si + r_sj;
    // S[j] is rewritten in the cycle the keystream address is read
    assign w_ks    = r_byp ? r_si : r_rdata;

    assign o_ready       = (r_state == ST_IDLE);
    assign w_accept      = i_valid & o_ready;
    assign o_valid       = r_ovalid;
    assign o_cipher_char = r_cipher;

    // RAM port control per step
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_n;
        w_wdata = r_n;
        w_raddr = r_n;
        unique case (r_state)
            ST_IDLE: begin
                w_raddr = w_i_inc;
            end
            ST_FILL: begin
                w_we = 1'b1;
            end
            ST_KA: begin
                w_raddr = r_n;
            end
            ST_KB: begin
                w_raddr = w_ks_j;
            end
            ST_KC: begin
                w_we    = 1'b1;
                w_waddr = r_n;
                w_wdata = r_rdata;
            end
            ST_KD: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
            end
            ST_PA: begin
                w_raddr = w_i_inc;
            end
            ST_PB: begin
                w_raddr = w_pr_j;
            end
            ST_PC: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_rdata;
            end
            ST_PD: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                w_raddr = w_t;
            end
            ST_PE: begin
                // keep the keystream entry on the read port while stalled
                w_raddr = w_t;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_perm[w_waddr] <= w_wdata;
        end
        r_rdata <= r_perm[w_raddr];
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]  <= '0;
            r_key[1]  <= '0;
            r_key[2]  <= '0;
            r_key[3]  <= '0;
            r_key_len <= rc4sc_pkg::KEY_LEN_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rc4sc_pkg::CFG_KEY0:    r_key[0]  <= i_cfg_data;
                rc4sc_pkg::CFG_KEY1:    r_key[1]  <= i_cfg_data;
                rc4sc_pkg::CFG_KEY2:    r_key[2]  <= i_cfg_data;
                rc4sc_pkg::CFG_KEY3:    r_key[3]  <= i_cfg_data;
                rc4sc_pkg::CFG_KEY_LEN: r_key_len <= i_cfg_data[rc4sc_pkg::KEY_LEN_W-1:0];
                default: begin
                    r_key_len <= r_key_len;
                end
            endcase
        end
    end

    // Sequencer: schedule (fill, swap sweep) then per-word generation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_sched  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // a word finishing in PE reloads the output register itself
            if (r_ovalid && i_ready && (r_state != ST_PE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_text <= i_text_char;
                        if (i_message_start || !r_sched) begin
                            r_n     <= '0;
                            r_state <= ST_FILL;
                        end else begin
                            r_i     <= w_i_inc;
                            r_state <= ST_PB;
                        end
                    end
                end
                ST_FILL: begin
                    r_n <= r_n + 8'd1;
                    if (r_n == LAST_ENTRY) begin
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= ST_KA;
                    end
                end
                ST_KA: begin
                    r_state <= ST_KB;
                end
                ST_KB: begin
                    r_j     <= w_ks_j;
                    r_si    <= r_rdata;
                    r_state <= ST_KC;
                end
                ST_KC: begin
                    r_state <= ST_KD;
                end
                ST_KD: begin
                    r_n <= r_n + 8'd1;
                    r_k <= w_k_next;
                    if (r_n == LAST_ENTRY) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_sched <= 1'b1;
                        r_state <= ST_PA;
                    end else begin
                        r_state <= ST_KA;
                    end
                end
                ST_PA: begin
                    r_i     <= w_i_inc;
                    r_state <= ST_PB;
                end
                ST_PB: begin
                    r_j     <= w_pr_j;
                    r_si    <= r_rdata;
                    r_state <= ST_PC;
                end
                ST_PC: begin
                    r_sj    <= r_rdata;
                    r_state <= ST_PD;
                end
                ST_PD: begin
                    r_byp   <= (w_t == r_j);
                    r_state <= ST_PE;
                end
                ST_PE: begin
                    // wait for the output register to free up
                    if (!r_ovalid || i_ready) begin
                        r_cipher <= {r_text[rc4sc_pkg::CHAR_W-1:rc4sc_pkg::BYTE_W],
                                     r_text[rc4sc_pkg::BYTE_W-1:0] ^ w_ks};
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
